// File: sv/nfcs_pkg.sv
// Shared types, command codes and the bus cycle table of the NAND flash command sequencer.
package nfcs_pkg;

   localparam int unsigned PAGE_DATA_BYTES = 512;

   localparam logic [7:0]  CMD_READ_SPARE    = 8'h50;
   localparam logic [7:0]  CMD_SERIAL_INPUT  = 8'h80;
   localparam logic [7:0]  CMD_PROGRAM       = 8'h10;
   localparam logic [7:0]  CMD_READ_STATUS   = 8'h70;
   localparam logic [7:0]  CMD_ERASE_SETUP   = 8'h60;
   localparam logic [7:0]  CMD_ERASE_CONFIRM = 8'hD0;
   localparam logic [7:0]  CMD_RESET         = 8'hFF;
   localparam logic [7:0]  STATUS_PASS_BYTE  = 8'hC0;
   localparam logic [15:0] POLL_LIMIT_RESET  = 16'd5000;
   localparam logic [15:0] POLL_COUNT_MAX    = 16'hFFFF;

   typedef enum logic [2:0] {
      OP_RESET         = 3'd0,
      OP_READ_START    = 3'd1,
      OP_WRITE_START   = 3'd2,
      OP_ERASE         = 3'd3,
      OP_WRITE_BYTE    = 3'd4,
      OP_READ_BYTE     = 3'd5,
      OP_PROGRAM       = 3'd6,
      OP_STATUS_POLL   = 3'd7
   } nfcs_op_type;

   typedef enum logic [1:0] {
      KIND_CMD   = 2'd0,
      KIND_ADDR  = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_READ  = 2'd3
   } nfcs_kind_type;

   typedef enum logic [1:0] {
      ST_NONE    = 2'd0,
      ST_PASS    = 2'd1,
      ST_FAIL    = 2'd2,
      ST_PENDING = 2'd3
   } nfcs_status_type;

   // One classified operation as it waits between the front and the back.
   typedef struct packed {
      nfcs_op_type     op;
      logic [7:0]      ptr_byte;
      logic [7:0]      col_byte;
      logic [23:0]     row;
      logic [7:0]      data_byte;
      nfcs_status_type status;
   } nfcs_desc_type;

   // One bus cycle as it is shown on the result side.
   typedef struct packed {
      nfcs_kind_type   kind;
      logic [7:0]      bus_byte;
      logic [7:0]      read_data;
      nfcs_status_type status;
      logic            last;
   } nfcs_cycle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } nfcs_queue_status_type;

   function automatic nfcs_cycle_type make_cycle(nfcs_kind_type kind, logic [7:0] bus_byte,
                                                 logic [7:0] read_data,
                                                 nfcs_status_type status, logic last);
      nfcs_cycle_type c;
      c.kind      = kind;
      c.bus_byte  = bus_byte;
      c.read_data = read_data;
      c.status    = status;
      c.last      = last;
      return c;
   endfunction

   // Bus cycle number step of a classified operation.
   function automatic nfcs_cycle_type cycle_at(nfcs_desc_type d, logic [2:0] step);
      nfcs_cycle_type c;
      c = make_cycle(KIND_CMD, CMD_RESET, 8'h00, ST_NONE, 1'b1);
      unique case (d.op)
         OP_RESET: begin
            c = make_cycle(KIND_CMD, CMD_RESET, 8'h00, ST_NONE, 1'b1);
         end
         OP_READ_START: begin
            case (step)
               3'd0:    c = make_cycle(KIND_CMD, d.ptr_byte, 8'h00, ST_NONE, 1'b0);
               3'd1:    c = make_cycle(KIND_ADDR, d.col_byte, 8'h00, ST_NONE, 1'b0);
               3'd2:    c = make_cycle(KIND_ADDR, d.row[7:0], 8'h00, ST_NONE, 1'b0);
               3'd3:    c = make_cycle(KIND_ADDR, d.row[15:8], 8'h00, ST_NONE, 1'b0);
               default: c = make_cycle(KIND_ADDR, d.row[23:16], 8'h00, ST_NONE, 1'b1);
            endcase
         end
         OP_WRITE_START: begin
            case (step)
               3'd0:    c = make_cycle(KIND_CMD, d.ptr_byte, 8'h00, ST_NONE, 1'b0);
               3'd1:    c = make_cycle(KIND_CMD, CMD_SERIAL_INPUT, 8'h00, ST_NONE, 1'b0);
               3'd2:    c = make_cycle(KIND_ADDR, d.col_byte, 8'h00, ST_NONE, 1'b0);
               3'd3:    c = make_cycle(KIND_ADDR, d.row[7:0], 8'h00, ST_NONE, 1'b0);
               3'd4:    c = make_cycle(KIND_ADDR, d.row[15:8], 8'h00, ST_NONE, 1'b0);
               default: c = make_cycle(KIND_ADDR, d.row[23:16], 8'h00, ST_NONE, 1'b1);
            endcase
         end
         OP_ERASE: begin
            case (step)
               3'd0:    c = make_cycle(KIND_CMD, CMD_ERASE_SETUP, 8'h00, ST_NONE, 1'b0);
               3'd1:    c = make_cycle(KIND_ADDR, d.row[7:0], 8'h00, ST_NONE, 1'b0);
               3'd2:    c = make_cycle(KIND_ADDR, d.row[15:8], 8'h00, ST_NONE, 1'b0);
               3'd3:    c = make_cycle(KIND_ADDR, d.row[23:16], 8'h00, ST_NONE, 1'b0);
               3'd4:    c = make_cycle(KIND_CMD, CMD_ERASE_CONFIRM, 8'h00, ST_NONE, 1'b0);
               default: c = make_cycle(KIND_READ, 8'h00, d.data_byte, d.status, 1'b1);
            endcase
         end
         OP_WRITE_BYTE: begin
            c = make_cycle(KIND_WRITE, d.data_byte, 8'h00, ST_NONE, 1'b1);
         end
         OP_READ_BYTE: begin
            c = make_cycle(KIND_READ, 8'h00, d.data_byte, ST_NONE, 1'b1);
         end
         OP_PROGRAM: begin
            case (step)
               3'd0:    c = make_cycle(KIND_CMD, CMD_PROGRAM, 8'h00, ST_NONE, 1'b0);
               3'd1:    c = make_cycle(KIND_CMD, CMD_READ_STATUS, 8'h00, ST_NONE, 1'b0);
               default: c = make_cycle(KIND_READ, 8'h00, d.data_byte, d.status, 1'b1);
            endcase
         end
         OP_STATUS_POLL: begin
            c = make_cycle(KIND_READ, 8'h00, d.data_byte, d.status, 1'b1);
         end
         default: begin
            c = make_cycle(KIND_CMD, CMD_RESET, 8'h00, ST_NONE, 1'b1);
         end
      endcase
      return c;
   endfunction

endpackage

// File: sv/nfcs_front.sv
// Front end: takes operation words, holds the poll limit and counter, and classifies each word.
module nfcs_front
   import nfcs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic [15:0]   csr_write_data,
   input  logic          accept,
   input  logic [2:0]    req_command,
   input  logic [9:0]    req_column,
   input  logic [23:0]   req_row,
   input  logic [7:0]    req_write_byte,
   input  logic [7:0]    req_bus_read_byte,
   output nfcs_desc_type desc
);

   logic [15:0]     poll_limit_ff;
   logic [15:0]     poll_limit_in;
   logic [15:0]     poll_count_ff;
   logic [15:0]     poll_count_in;
   logic [9:0]      spare_column;
   logic [15:0]     reads_made;
   nfcs_op_type     op;
   nfcs_status_type judged;
   logic [15:0]     judged_count;

   assign op            = nfcs_op_type'(req_command);
   assign spare_column  = req_column - 10'(PAGE_DATA_BYTES);
   assign poll_limit_in = csr_write_enable ? csr_write_data : poll_limit_ff;

   // Status read count including the read made by this word.
   assign reads_made = (op == OP_PROGRAM) ? 16'd1 :
                       (poll_count_ff != POLL_COUNT_MAX) ? poll_count_ff + 16'd1 :
                       poll_count_ff;

   always_comb begin
      if (req_bus_read_byte == STATUS_PASS_BYTE) begin
         judged       = ST_PASS;
         judged_count = 16'd0;
      end else if (reads_made >= poll_limit_ff) begin
         judged       = ST_FAIL;
         judged_count = 16'd0;
      end else begin
         judged       = ST_PENDING;
         judged_count = reads_made;
      end
   end

   always_comb begin
      desc.op        = op;
      desc.row       = req_row;
      desc.status    = ST_NONE;
      desc.data_byte = req_bus_read_byte;
      if (req_column >= 10'(PAGE_DATA_BYTES)) begin
         desc.ptr_byte = CMD_READ_SPARE;
         desc.col_byte = spare_column[7:0];
      end else begin
         desc.ptr_byte = {7'd0, req_column[8]};
         desc.col_byte = req_column[7:0];
      end
      poll_count_in = poll_count_ff;
      unique case (op)
         OP_RESET: begin
            poll_count_in = 16'd0;
         end
         OP_ERASE: begin
            desc.status = req_bus_read_byte[0] ? ST_FAIL : ST_PASS;
         end
         OP_WRITE_BYTE: begin
            desc.data_byte = req_write_byte;
         end
         OP_PROGRAM, OP_STATUS_POLL: begin
            desc.status   = judged;
            poll_count_in = judged_count;
         end
         default: begin
            poll_count_in = poll_count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_limit_ff <= POLL_LIMIT_RESET;
         poll_count_ff <= 16'd0;
      end else begin
         poll_limit_ff <= poll_limit_in;
         if (accept) begin
            poll_count_ff <= poll_count_in;
         end
      end
   end

endmodule

// File: sv/nfcs_queue.sv
// Short register queue of classified operations between the front and the back.
module nfcs_queue
   import nfcs_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  nfcs_desc_type         push_desc,
   input  logic                  pop,
   output nfcs_desc_type         head_desc,
   output nfcs_queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   nfcs_desc_type    slots_ff [DEPTH];
   logic [PTR_W-1:0] head_ff;
   logic [PTR_W-1:0] head_in;
   logic [PTR_W-1:0] tail_ff;
   logic [PTR_W-1:0] tail_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_desc    = slots_ff[head_ff];

   assign head_in  = !do_pop ? head_ff :
                     (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_in  = !do_push ? tail_ff :
                     (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[tail_ff] <= push_desc;
      end
   end

endmodule

// File: sv/nfcs_back.sv
// Back end: steps through the bus cycles of the oldest queued operation into the result register.
module nfcs_back
   import nfcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  nfcs_desc_type         head_desc,
   input  nfcs_queue_status_type queue_status,
   output logic                  queue_pop,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output nfcs_cycle_type        rsp_cycle
);

   logic           out_valid_ff;
   logic           out_valid_in;
   logic [2:0]     step_ff;
   logic [2:0]     step_in;
   nfcs_cycle_type cycle_ff;
   nfcs_cycle_type next_cycle;
   logic           advance;

   assign next_cycle   = cycle_at(head_desc, step_ff);
   assign advance      = !queue_status.empty && (!out_valid_ff || rsp_pop);
   assign queue_pop    = advance && next_cycle.last;
   assign out_valid_in = advance || (out_valid_ff && !rsp_pop);
   assign step_in      = !advance ? step_ff : (next_cycle.last ? 3'd0 : step_ff + 3'd1);
   assign rsp_empty    = !out_valid_ff;
   assign rsp_cycle    = cycle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         step_ff      <= 3'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cycle_ff <= next_cycle;
      end
   end

endmodule

// File: sv/nand_flash_command_sequencer.sv
// Top level of the small-page NAND flash command sequencer.
//
// Each operation word pushed on the req_ side turns into a run of one to six
// bus cycle words on the rsp_ side, in bus order, with rsp_last set on the
// final cycle of the operation. The front end classifies an operation in the
// cycle it is pushed: it works out the pointer command and column byte,
// judges the status byte for erase, program confirm and status polls, and
// keeps the program poll counter against the csr_ poll limit. Classified
// operations wait in a QUEUE_DEPTH entry queue, so req_full rises only when
// that queue is full. The back end emits one bus cycle per clock into the
// result register while no unpopped word holds it back, and that register
// refills in the same cycle it is popped. An operation has one bus cycle
// for reset, data and poll words, three for program confirm, five for read
// start and six for write start and erase; with rsp_pop held high the
// result side carries one word every clock. The poll limit is written
// through csr_write_enable and csr_write_data, by the user only while the
// block is idle, which the block itself does not enforce; it resets to 5000.
module nand_flash_command_sequencer
   import nfcs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_command,
   input  logic [9:0]  req_column,
   input  logic [23:0] req_row,
   input  logic [7:0]  req_write_byte,
   input  logic [7:0]  req_bus_read_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_cycle_kind,
   output logic [7:0]  rsp_bus_byte,
   output logic [7:0]  rsp_read_data,
   output logic [1:0]  rsp_op_status,
   output logic        rsp_last
);

   nfcs_desc_type         front_desc;
   nfcs_desc_type         head_desc;
   nfcs_queue_status_type queue_status;
   nfcs_cycle_type        rsp_cycle;
   logic                  accept;
   logic                  queue_pop;

   // A word is taken whenever the queue has room.
   assign req_full = queue_status.full;
   assign accept   = req_push && !queue_status.full;

   nfcs_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .accept            (accept),
      .req_command       (req_command),
      .req_column        (req_column),
      .req_row           (req_row),
      .req_write_byte    (req_write_byte),
      .req_bus_read_byte (req_bus_read_byte),
      .desc              (front_desc)
   );

   nfcs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_desc (front_desc),
      .pop       (queue_pop),
      .head_desc (head_desc),
      .status    (queue_status)
   );

   nfcs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_desc    (head_desc),
      .queue_status (queue_status),
      .queue_pop    (queue_pop),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_cycle    (rsp_cycle)
   );

   // The result register drives the payload ports directly.
   assign rsp_cycle_kind = rsp_cycle.kind;
   assign rsp_bus_byte   = rsp_cycle.bus_byte;
   assign rsp_read_data  = rsp_cycle.read_data;
   assign rsp_op_status  = rsp_cycle.status;
   assign rsp_last       = rsp_cycle.last;

endmodule

// File: sv/nfcs_checker.sv
// Port-level checks of the NAND flash command sequencer and the bind that attaches them.
module nfcs_checker
   import nfcs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [1:0]  rsp_cycle_kind,
   input logic [7:0]  rsp_bus_byte,
   input logic [7:0]  rsp_read_data,
   input logic [1:0]  rsp_op_status,
   input logic        rsp_last
);

   // Nothing is shown on the result side right after reset.
   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result side not empty after reset");

   // A word that is shown and not taken stays as it is.
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_cycle_kind) &&
         $stable(rsp_bus_byte) && $stable(rsp_read_data) &&
         $stable(rsp_op_status) && $stable(rsp_last)))
      else $error("pending result word changed before it was taken");

   // Captured data and status travel only on read cycles, which drive nothing.
   a_read_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_cycle_kind != KIND_READ) |->
         (rsp_read_data == 8'h00 && rsp_op_status == ST_NONE))
      else $error("read data or status on a cycle that is not a read");

   a_read_drives_nothing: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_cycle_kind == KIND_READ) |-> (rsp_bus_byte == 8'h00))
      else $error("read cycle drives the data pins");

   // The only operation that ends on a command cycle is the reset command.
   a_command_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_last && rsp_cycle_kind == KIND_CMD) |->
         (rsp_bus_byte == CMD_RESET))
      else $error("operation ends on a command other than reset");

endmodule

bind nand_flash_command_sequencer nfcs_checker u_nfcs_checker (.*);

// File: dv/nand_flash_command_sequencer_test.sv
// Self-checking testbench for the NAND flash command sequencer.
`timescale 1ns / 100ps

module nand_flash_command_sequencer_test
   import nfcs_pkg::*;
();

   // After the last expected word the block is given this many clocks to show
   // anything it should not.
   localparam int SETTLE_CYCLES = 12;
   // Length of the long result-side hold that backs the block up into req_full.
   localparam int HOLD_CYCLES = 80;
   localparam int REPORT_LIMIT = 10;

   // One operation word as it is offered on the req_ side.
   typedef struct {
      nfcs_op_type op;
      logic [9:0]  column;
      logic [23:0] row;
      logic [7:0]  wbyte;
      logic [7:0]  rbyte;
   } flash_op_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [2:0]  req_command = '0;
   logic [9:0]  req_column = '0;
   logic [23:0] req_row = '0;
   logic [7:0]  req_write_byte = '0;
   logic [7:0]  req_bus_read_byte = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [1:0]  rsp_cycle_kind;
   logic [7:0]  rsp_bus_byte;
   logic [7:0]  rsp_read_data;
   logic [1:0]  rsp_op_status;
   logic        rsp_last;

   // Operations waiting to be offered, and bus cycle words predicted but not yet seen.
   flash_op_type   pending_ops[$];
   nfcs_cycle_type expected_cycles[$];

   // Our own copy of the block's program poll counter and the poll limit register.
   logic [15:0] program_polls = '0;
   logic [15:0] poll_limit_now = POLL_LIMIT_RESET;

   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   int ops_queued = 0;
   int ops_accepted = 0;
   int words_checked = 0;
   int full_stalls = 0;
   int mismatches = 0;
   int status_seen[4] = '{0, 0, 0, 0};

   nand_flash_command_sequencer u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_command       (req_command),
      .req_column        (req_column),
      .req_row           (req_row),
      .req_write_byte    (req_write_byte),
      .req_bus_read_byte (req_bus_read_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_cycle_kind    (rsp_cycle_kind),
      .rsp_bus_byte      (rsp_bus_byte),
      .rsp_read_data     (rsp_read_data),
      .rsp_op_status     (rsp_op_status),
      .rsp_last          (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   function automatic nfcs_cycle_type bus_word(nfcs_kind_type kind, logic [7:0] pins,
                                               logic [7:0] captured, nfcs_status_type st);
      nfcs_cycle_type w;
      w.kind      = kind;
      w.bus_byte  = pins;
      w.read_data = captured;
      w.status    = st;
      w.last      = 1'b0;
      return w;
   endfunction

   // A status byte of 0xC0 always passes. Anything else fails once the program
   // has used up its poll budget and otherwise leaves the program pending.
   // Either verdict ends the program, so the counter starts over.
   function automatic nfcs_status_type judge_program_status(logic [7:0] status_byte);
      if (status_byte == STATUS_PASS_BYTE) begin
         program_polls = '0;
         return ST_PASS;
      end
      if (program_polls >= poll_limit_now) begin
         program_polls = '0;
         return ST_FAIL;
      end
      return ST_PENDING;
   endfunction

   // Works out the run of bus cycles that one accepted operation causes and
   // appends it to the expected words, with the last flag on its final cycle.
   function automatic void predict_bus_cycles(flash_op_type t);
      nfcs_cycle_type  run[$];
      logic [9:0]      col;
      logic [7:0]      pointer;
      nfcs_status_type st;
      col = t.column;
      // Spare area columns select the 0x50 pointer and are rebased to zero.
      // Columns past the spare area are rebased the same way and simply
      // truncated to the address byte.
      if (col >= PAGE_DATA_BYTES) begin
         pointer = CMD_READ_SPARE;
         col     = col - 10'(PAGE_DATA_BYTES);
      end else begin
         pointer = {7'd0, col[8]};
      end
      case (t.op)
         OP_RESET: begin
            // A reset also abandons any program still waiting on status.
            program_polls = '0;
            run.push_back(bus_word(KIND_CMD, CMD_RESET, 8'h00, ST_NONE));
         end
         OP_READ_START, OP_WRITE_START: begin
            run.push_back(bus_word(KIND_CMD, pointer, 8'h00, ST_NONE));
            if (t.op == OP_WRITE_START) begin
               run.push_back(bus_word(KIND_CMD, CMD_SERIAL_INPUT, 8'h00, ST_NONE));
            end
            run.push_back(bus_word(KIND_ADDR, col[7:0], 8'h00, ST_NONE));
            run.push_back(bus_word(KIND_ADDR, t.row[7:0], 8'h00, ST_NONE));
            run.push_back(bus_word(KIND_ADDR, t.row[15:8], 8'h00, ST_NONE));
            run.push_back(bus_word(KIND_ADDR, t.row[23:16], 8'h00, ST_NONE));
         end
         OP_ERASE: begin
            run.push_back(bus_word(KIND_CMD, CMD_ERASE_SETUP, 8'h00, ST_NONE));
            run.push_back(bus_word(KIND_ADDR, t.row[7:0], 8'h00, ST_NONE));
            run.push_back(bus_word(KIND_ADDR, t.row[15:8], 8'h00, ST_NONE));
            run.push_back(bus_word(KIND_ADDR, t.row[23:16], 8'h00, ST_NONE));
            run.push_back(bus_word(KIND_CMD, CMD_ERASE_CONFIRM, 8'h00, ST_NONE));
            // Erase status is judged on bit 0 alone and does not touch the counter.
            st = t.rbyte[0] ? ST_FAIL : ST_PASS;
            run.push_back(bus_word(KIND_READ, 8'h00, t.rbyte, st));
         end
         OP_WRITE_BYTE: begin
            run.push_back(bus_word(KIND_WRITE, t.wbyte, 8'h00, ST_NONE));
         end
         OP_READ_BYTE: begin
            run.push_back(bus_word(KIND_READ, 8'h00, t.rbyte, ST_NONE));
         end
         OP_PROGRAM: begin
            run.push_back(bus_word(KIND_CMD, CMD_PROGRAM, 8'h00, ST_NONE));
            run.push_back(bus_word(KIND_CMD, CMD_READ_STATUS, 8'h00, ST_NONE));
            // The status read that follows the confirm is the first poll.
            program_polls = 16'd1;
            st = judge_program_status(t.rbyte);
            run.push_back(bus_word(KIND_READ, 8'h00, t.rbyte, st));
         end
         default: begin
            // Status poll. The counter saturates rather than wrapping, and a
            // poll with no program pending simply counts up from zero.
            if (program_polls != POLL_COUNT_MAX) begin
               program_polls = program_polls + 16'd1;
            end
            st = judge_program_status(t.rbyte);
            run.push_back(bus_word(KIND_READ, 8'h00, t.rbyte, st));
         end
      endcase
      run[run.size() - 1].last = 1'b1;
      foreach (run[i]) begin
         expected_cycles.push_back(run[i]);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: offers the oldest pending operation, idling at random.
   // ---------------------------------------------------------------------

   // The offered word is always the head of pending_ops, and only this block
   // removes entries, so on acceptance the head is exactly what the block took.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predict_bus_cycles(pending_ops.pop_front());
            ops_accepted++;
         end else if (req_push) begin
            full_stalls++;
         end
         if (pending_ops.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_push          <= 1'b1;
            req_command       <= pending_ops[0].op;
            req_column        <= pending_ops[0].column;
            req_row           <= pending_ops[0].row;
            req_write_byte    <= pending_ops[0].wbyte;
            req_bus_read_byte <= pending_ops[0].rbyte;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: pops result words at random and checks each one in order.
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      nfcs_cycle_type got;
      nfcs_cycle_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got.kind      = nfcs_kind_type'(rsp_cycle_kind);
            got.bus_byte  = rsp_bus_byte;
            got.read_data = rsp_read_data;
            got.status    = nfcs_status_type'(rsp_op_status);
            got.last      = rsp_last;
            status_seen[rsp_op_status]++;
            if (expected_cycles.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("unexpected bus cycle word: kind %0d byte %h read %h",
                           got.kind, got.bus_byte, got.read_data);
                  $display("   status %0d last %b", got.status, got.last);
               end
            end else begin
               want = expected_cycles.pop_front();
               words_checked++;
               if (got.kind != want.kind || got.bus_byte != want.bus_byte ||
                   got.read_data != want.read_data || got.status != want.status ||
                   got.last != want.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("bus cycle word %0d differs:", words_checked);
                     $display("   expected kind %0d byte %h read %h status %0d last %b",
                              want.kind, want.bus_byte, want.read_data, want.status, want.last);
                     $display("   actual   kind %0d byte %h read %h status %0d last %b",
                              got.kind, got.bus_byte, got.read_data, got.status, got.last);
                  end
               end
            end
         end
         // A hold request from the stimulus freezes the result side for a
         // long stretch so that the operation queue fills and req_full rises.
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   function automatic void push_op(flash_op_type t);
      pending_ops.push_back(t);
      ops_queued++;
   endfunction

   function automatic void queue_op(nfcs_op_type op, logic [9:0] column, logic [23:0] row,
                                    logic [7:0] wbyte, logic [7:0] rbyte);
      flash_op_type t;
      t.op     = op;
      t.column = column;
      t.row    = row;
      t.wbyte  = wbyte;
      t.rbyte  = rbyte;
      push_op(t);
   endfunction

   // Every field random, including the ones the operation does not use. Half
   // the columns stay inside page and spare area, the rest span all ten bits.
   function automatic flash_op_type any_op(nfcs_op_type op);
      flash_op_type t;
      t.op     = op;
      t.column = $urandom_range(1) ? 10'($urandom_range(527)) : 10'($urandom_range(1023));
      t.row    = 24'($urandom);
      t.wbyte  = 8'($urandom);
      t.rbyte  = 8'($urandom);
      return t;
   endfunction

   function automatic logic [7:0] status_byte();
      return ($urandom_range(3) == 0) ? STATUS_PASS_BYTE : 8'($urandom);
   endfunction

   // Mostly well-formed flash sequences (load and program a page, read a page,
   // erase a block) with random content, mixed with resets and loose words.
   task automatic queue_random_ops(input int count);
      int           goal;
      int           n;
      flash_op_type t;
      goal = ops_queued + count;
      while (ops_queued < goal) begin
         case ($urandom_range(9))
            0, 1, 2: begin
               push_op(any_op(OP_WRITE_START));
               n = $urandom_range(1, 4);
               repeat (n) push_op(any_op(OP_WRITE_BYTE));
               t = any_op(OP_PROGRAM);
               t.rbyte = status_byte();
               push_op(t);
               n = $urandom_range(0, 4);
               repeat (n) begin
                  t = any_op(OP_STATUS_POLL);
                  t.rbyte = status_byte();
                  push_op(t);
               end
            end
            3, 4: begin
               push_op(any_op(OP_READ_START));
               n = $urandom_range(1, 4);
               repeat (n) push_op(any_op(OP_READ_BYTE));
            end
            5: push_op(any_op(OP_ERASE));
            6: push_op(any_op(OP_RESET));
            default: push_op(any_op(nfcs_op_type'($urandom_range(7))));
         endcase
      end
   endtask

   // Waits until every operation has been taken and every word has come back,
   // then lets the block settle so that no stray word can slip by.
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_ops.size() != 0 || expected_cycles.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The poll limit is only written while the block is idle.
   task automatic write_poll_limit(input logic [15:0] limit);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      poll_limit_now = limit;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pass with a small poll limit so that every verdict shows up.
      sender_idle_pct   = 23;
      receiver_idle_pct = 88;
      write_poll_limit(16'd2);
      queue_op(OP_RESET, 10'd0, 24'd0, 8'h00, 8'h00);
      queue_op(OP_READ_START, 10'd0, 24'h000000, 8'hFF, 8'hFF);
      queue_op(OP_READ_START, 10'd511, 24'hFFFFFF, 8'h00, 8'h00);
      queue_op(OP_READ_START, 10'd256, 24'h5A3C81, 8'h00, 8'h00);
      queue_op(OP_WRITE_START, 10'd512, 24'h123456, 8'h00, 8'h00);
      queue_op(OP_WRITE_START, 10'd527, 24'hA5C3E7, 8'h00, 8'h00);
      // Columns past the spare area wrap into the address byte unreported.
      queue_op(OP_READ_START, 10'd1023, 24'h000001, 8'h00, 8'h00);
      queue_op(OP_WRITE_BYTE, 10'd0, 24'd0, 8'h00, 8'h00);
      queue_op(OP_WRITE_BYTE, 10'd0, 24'd0, 8'hFF, 8'h00);
      queue_op(OP_READ_BYTE, 10'd0, 24'd0, 8'h00, 8'h00);
      queue_op(OP_READ_BYTE, 10'd0, 24'd0, 8'h00, 8'hFF);
      queue_op(OP_ERASE, 10'd0, 24'h00FF00, 8'h00, 8'hE0);
      queue_op(OP_ERASE, 10'd0, 24'hFF00FF, 8'h00, 8'h01);
      queue_op(OP_PROGRAM, 10'd0, 24'd0, 8'h00, STATUS_PASS_BYTE);
      queue_op(OP_PROGRAM, 10'd0, 24'd0, 8'h00, 8'h80);
      queue_op(OP_STATUS_POLL, 10'd0, 24'd0, 8'h00, 8'h80);
      // Polls with no program outstanding still count and judge the byte.
      queue_op(OP_STATUS_POLL, 10'd0, 24'd0, 8'h00, STATUS_PASS_BYTE);
      queue_op(OP_STATUS_POLL, 10'd0, 24'd0, 8'h00, 8'h00);
      // A reset in the middle of a program abandons it.
      queue_op(OP_PROGRAM, 10'd0, 24'd0, 8'h00, 8'h00);
      queue_op(OP_RESET, 10'd0, 24'd0, 8'h00, 8'h00);
      queue_op(OP_STATUS_POLL, 10'd0, 24'd0, 8'h00, 8'h00);
      queue_op(OP_STATUS_POLL, 10'd0, 24'd0, 8'h00, 8'h7F);
      wait_drained();

      // With a limit of zero every status byte but 0xC0 fails at once.
      write_poll_limit(16'd0);
      queue_op(OP_PROGRAM, 10'd0, 24'd0, 8'h00, 8'h00);
      queue_op(OP_STATUS_POLL, 10'd0, 24'd0, 8'h00, STATUS_PASS_BYTE);
      queue_op(OP_STATUS_POLL, 10'd0, 24'd0, 8'h00, 8'h01);
      wait_drained();

      // Largest limit: programs stay pending through the random mix.
      sender_idle_pct   = 88;
      receiver_idle_pct = 23;
      write_poll_limit(16'hFFFF);
      queue_random_ops(32);
      wait_drained();

      // Limit of one, no idling on either side, and a long result-side hold
      // while the sender keeps pushing so the block backs up into req_full.
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      write_poll_limit(16'd1);
      queue_random_ops(32);
      hold_requests++;
      wait_drained();

      write_poll_limit(16'($urandom_range(2, 4)));
      queue_random_ops(32);
      wait_drained();

      $display("covered %0d operations and %0d bus cycle words", ops_accepted, words_checked);
      $display("   over poll limits 2, 0, 65535, 1 and a small random one");
      $display("status verdicts pass %0d, fail %0d, pending %0d; sender stalled %0d cycles",
               status_seen[ST_PASS], status_seen[ST_FAIL], status_seen[ST_PENDING],
               full_stalls);
      if (mismatches == 0 && expected_cycles.size() == 0) begin
         $display("nand_flash_command_sequencer: match");
      end else begin
         $display("nand_flash_command_sequencer: mismatch");
      end
      $finish;
   end

   // Far beyond the slowest correct run: every word held back by the slow
   // receiver, the long hold, and every operation at six bus cycles.
   initial begin
      #5000000;
      $display("timed out waiting for the sequencer to drain");
      $display("nand_flash_command_sequencer: mismatch");
      $finish;
   end

endmodule
